// File: rtl/cor_pkg.sv
// shared types and constants for the circle octant rasterizer
// widths, register indexes, controller states and command/status structs
// no dependencies
package cor_pkg;

  localparam int COORD_BITS = 12;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int D_W        = 2 * RAD_W;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int REM_W      = RAD_W + 1;
  localparam int TRY_W      = RAD_W + 3;
  localparam int OUT_W      = COORD_BITS + 2;
  localparam int ROOT_CNT_W = $clog2(RAD_W);
  localparam int PT_IDX_W   = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;

  localparam logic [PT_IDX_W-1:0] PT_LAST = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUB,
    ST_ROOT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clr_col;
    logic mul_en;
    logic root_init;
    logic root_step;
    logic pt_adv;
    logic col_inc;
  } cmd_t;

  typedef struct packed {
    logic root_last;
    logic pt_last;
    logic done;
  } sts_t;

endpackage

// File: rtl/cor_if.sv
// handshake channels of the circle octant rasterizer: step, point and config
// depends on cor_pkg
interface cor_step_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface cor_point_if;
  logic                             valid;
  logic                             ready;
  logic signed [cor_pkg::OUT_W-1:0] point_x;
  logic signed [cor_pkg::OUT_W-1:0] point_y;
  logic                             last_of_step;
  logic                             circle_done;
  modport source (output valid, output point_x, output point_y, output last_of_step,
                  output circle_done, input ready);
  modport sink (input valid, input point_x, input point_y, input last_of_step,
                input circle_done, output ready);
endinterface

interface cor_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cor_pkg::CFG_IDX_W-1:0]     index;
  logic [cor_pkg::COORD_BITS-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/cor_ctrl.sv
// controller of the circle octant rasterizer: step sequencing and run state
// depends on cor_pkg
module cor_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_restart_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cor_pkg::sts_t sts_i,
  output cor_pkg::cmd_t cmd_o
);

  cor_pkg::state_e state_q, state_d;
  logic            finished_q, finished_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cor_pkg::ST_IDLE;
      finished_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      finished_q <= finished_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cor_pkg::ST_IDLE: begin
        if (in_valid_i && (in_restart_i || !finished_q)) state_d = cor_pkg::ST_MUL;
      end
      cor_pkg::ST_MUL:  state_d = cor_pkg::ST_SUB;
      cor_pkg::ST_SUB:  state_d = cor_pkg::ST_ROOT;
      cor_pkg::ST_ROOT: begin
        if (sts_i.root_last) state_d = cor_pkg::ST_EMIT;
      end
      cor_pkg::ST_EMIT: begin
        if (out_ready_i && sts_i.pt_last) state_d = cor_pkg::ST_IDLE;
      end
      default: state_d = cor_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == cor_pkg::ST_IDLE);
    out_valid_o       = (state_q == cor_pkg::ST_EMIT);
    cmd_o.clr_col     = in_ready_o && in_valid_i && in_restart_i;
    cmd_o.mul_en      = (state_q == cor_pkg::ST_MUL);
    cmd_o.root_init   = (state_q == cor_pkg::ST_SUB);
    cmd_o.root_step   = (state_q == cor_pkg::ST_ROOT);
    cmd_o.pt_adv      = out_valid_o && out_ready_i;
    cmd_o.col_inc     = cmd_o.pt_adv && sts_i.pt_last && !sts_i.done;
    finished_d        = finished_q;
    if (cmd_o.clr_col) begin
      finished_d = 1'b0;
    end else if (cmd_o.pt_adv && sts_i.pt_last && sts_i.done) begin
      finished_d = 1'b1;
    end
  end

endmodule

// File: rtl/cor_datapath.sv
// datapath of the circle octant rasterizer: config registers, squares,
// bit-serial square root and eight-way point generation
// depends on cor_pkg
module cor_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cor_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cor_pkg::COORD_BITS-1:0]   cfg_data_i,
  input  cor_pkg::cmd_t                    cmd_i,
  output cor_pkg::sts_t                    sts_o,
  output logic signed [cor_pkg::OUT_W-1:0] point_x_o,
  output logic signed [cor_pkg::OUT_W-1:0] point_y_o,
  output logic                             last_of_step_o,
  output logic                             circle_done_o
);

  localparam int CB = cor_pkg::COORD_BITS;
  localparam int RW = cor_pkg::RAD_W;
  localparam int DW = cor_pkg::D_W;
  localparam int OW = cor_pkg::OUT_W;

  logic [CB-1:0]                 cx_q, cy_q, col_q;
  logic [RW-1:0]                 rad_q;
  logic [DW-1:0]                 rr_q;
  logic [cor_pkg::SQ_W-1:0]      xx_q;
  logic [DW-1:0]                 dsh_q, dsh_d;
  logic [cor_pkg::REM_W-1:0]     rem_q, rem_d;
  logic [RW-1:0]                 root_q, root_d;
  logic [cor_pkg::ROOT_CNT_W-1:0] cnt_q;
  logic [cor_pkg::PT_IDX_W-1:0]  pt_q;

  // config and run control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= '0;
      col_q <= '0;
      cnt_q <= '0;
      pt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          cor_pkg::REG_CENTER_X: cx_q  <= cfg_data_i;
          cor_pkg::REG_CENTER_Y: cy_q  <= cfg_data_i;
          cor_pkg::REG_RADIUS:   rad_q <= cfg_data_i[RW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr_col) begin
        col_q <= '0;
      end else if (cmd_i.col_inc) begin
        col_q <= col_q + CB'(1);
      end
      if (cmd_i.root_init) begin
        cnt_q <= '0;
      end else if (cmd_i.root_step) begin
        cnt_q <= cnt_q + cor_pkg::ROOT_CNT_W'(1);
      end
      if (cmd_i.root_init) begin
        pt_q <= '0;
      end else if (cmd_i.pt_adv) begin
        pt_q <= pt_q + cor_pkg::PT_IDX_W'(1);
      end
    end
  end

  // squares, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      rr_q <= DW'(rad_q) * DW'(rad_q);
      xx_q <= cor_pkg::SQ_W'(col_q) * cor_pkg::SQ_W'(col_q);
    end
  end

  // one result bit per cycle, two radicand bits brought down each time
  logic [cor_pkg::TRY_W-1:0] try_w, sub_w;
  always_comb begin
    try_w  = {rem_q, dsh_q[DW-1 -: 2]};
    sub_w  = cor_pkg::TRY_W'({root_q, 2'b01});
    dsh_d  = dsh_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (cmd_i.root_init) begin
      dsh_d  = (cor_pkg::SQ_W'(rr_q) > xx_q) ? DW'(cor_pkg::SQ_W'(rr_q) - xx_q) : '0;
      rem_d  = '0;
      root_d = '0;
    end else if (cmd_i.root_step) begin
      dsh_d = {dsh_q[DW-3:0], 2'b00};
      if (try_w >= sub_w) begin
        rem_d  = cor_pkg::REM_W'(try_w - sub_w);
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = cor_pkg::REM_W'(try_w);
        root_d = {root_q[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dsh_q  <= dsh_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // eight-way points; an inexact root pulls a positive negative-offset sum down by one
  logic          exact;
  logic [OW-1:0] a_w, b_w, x_w, s_w, na_w, nb_w;
  logic [OW-1:0] px_w, py_w;
  always_comb begin
    exact = (rem_q == '0);
    a_w   = OW'(cx_q);
    b_w   = OW'(cy_q);
    x_w   = OW'(col_q);
    s_w   = OW'(root_q);
    na_w  = a_w - s_w - OW'(!exact && (cx_q > CB'(root_q)));
    nb_w  = b_w - s_w - OW'(!exact && (cy_q > CB'(root_q)));
    unique case (pt_q)
      3'd0: begin px_w = a_w + x_w; py_w = b_w + s_w; end
      3'd1: begin px_w = a_w - x_w; py_w = b_w + s_w; end
      3'd2: begin px_w = a_w + x_w; py_w = nb_w;      end
      3'd3: begin px_w = a_w - x_w; py_w = nb_w;      end
      3'd4: begin px_w = a_w + s_w; py_w = b_w + x_w; end
      3'd5: begin px_w = na_w;      py_w = b_w + x_w; end
      3'd6: begin px_w = a_w + s_w; py_w = b_w - x_w; end
      default: begin px_w = na_w;   py_w = b_w - x_w; end
    endcase
  end

  assign point_x_o      = px_w;
  assign point_y_o      = py_w;
  assign last_of_step_o = (pt_q == cor_pkg::PT_LAST);
  assign circle_done_o  = sts_o.done;

  assign sts_o.root_last = (cnt_q == cor_pkg::ROOT_CNT_W'(RW - 1));
  assign sts_o.pt_last   = (pt_q == cor_pkg::PT_LAST);
  assign sts_o.done      = ((CB + 1)'(col_q) + (CB + 1)'(1)) > (CB + 1)'(root_q);

endmodule

// File: rtl/circle_octant_rasterizer_top.sv
// top level of the circle octant rasterizer
// depends on cor_pkg, cor_if, cor_ctrl and cor_datapath
//
// usage: write center_x (index 0), center_y (1) and radius (2) on cfg_i
// while the block is idle; cfg_i is always ready. each item on step_i is one
// column step: restart 1 starts a new circle at column zero, restart 0 moves
// to the next column. an active step gives eight point items on point_o, the
// eighth with last_of_step set; all eight carry circle_done on the final
// step. a step after the circle is finished gives nothing.
// timing: an active step computes the squares (ST_MUL), then the radicand
// (ST_SUB), then the square root (ST_ROOT, one result bit a cycle in the
// root unit) and then the eight points (ST_EMIT). step_i is ready only
// between steps. a stalled receiver holds the current point steady and the
// step simply stretches. reset clears the config, column and counter
// registers to zero and marks the circle finished, so nothing is drawn
// until a restart.
module circle_octant_rasterizer_top (
  input logic        clk_i,
  input logic        rst_ni,
  cor_step_if.sink   step_i,
  cor_point_if.source point_o,
  cor_cfg_if.sink    cfg_i
);

  cor_pkg::cmd_t cmd;
  cor_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  cor_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (step_i.valid),
    .in_restart_i (step_i.restart),
    .in_ready_o   (step_i.ready),
    .out_valid_o  (point_o.valid),
    .out_ready_i  (point_o.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  cor_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .point_x_o      (point_o.point_x),
    .point_y_o      (point_o.point_y),
    .last_of_step_o (point_o.last_of_step),
    .circle_done_o  (point_o.circle_done)
  );

endmodule

// File: rtl/cor_checker.sv
// port-level checks for the circle octant rasterizer, bound to the top level
// depends on cor_pkg and circle_octant_rasterizer_top
module cor_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [cor_pkg::OUT_W-1:0]   out_x_i,
  input logic [cor_pkg::OUT_W-1:0]   out_y_i,
  input logic                        out_last_i
);

  // one step at a time: no new item while points are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("step ready while points pending");

  // the squares, radicand and root lie between accept and the first point, so no point right after an accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("point too soon after step accept");

  // the eighth point closes the step
  a_step_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> !out_valid_i)
    else $error("points continue after last of step");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_x_i) && $stable(out_y_i)))
    else $error("stalled point changed");

endmodule

bind circle_octant_rasterizer_top cor_checker u_cor_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (step_i.valid),
  .in_ready_i  (step_i.ready),
  .out_valid_i (point_o.valid),
  .out_ready_i (point_o.ready),
  .out_x_i     (point_o.point_x),
  .out_y_i     (point_o.point_y),
  .out_last_i  (point_o.last_of_step)
);

// File: tb/sv/circle_octant_rasterizer_top_tb.sv
// self-checking testbench for circle_octant_rasterizer_top: directed and random column steps
// a scoreboard class predicts the eight symmetric points of every step and checks them in order
// depends on cor_pkg, cor_if and the rtl of the block

typedef struct packed {
  logic signed [cor_pkg::OUT_W-1:0] px;
  logic signed [cor_pkg::OUT_W-1:0] py;
  logic                             last_pt;
  logic                             done_pt;
} point_t;

class circle_scoreboard;
  logic [cor_pkg::COORD_BITS-1:0] cen_x;
  logic [cor_pkg::COORD_BITS-1:0] cen_y;
  logic [cor_pkg::RAD_W-1:0]      rad;
  logic [cor_pkg::COORD_BITS-1:0] column;
  bit                             finished;
  point_t                         awaited_pts[$];
  int unsigned                    errors;
  int unsigned                    steps_seen;
  int unsigned                    steps_drawn;
  int unsigned                    circles;
  int unsigned                    points_ok;

  function new();
    cen_x = '0;
    cen_y = '0;
    rad = '0;
    column = '0;
    finished = 1'b1;
    errors = 0;
    steps_seen = 0;
    steps_drawn = 0;
    circles = 0;
    points_ok = 0;
  endfunction

  function void set_reg(logic [cor_pkg::CFG_IDX_W-1:0] idx,
                        logic [cor_pkg::COORD_BITS-1:0] data);
    case (idx)
      cor_pkg::REG_CENTER_X: cen_x = data;
      cor_pkg::REG_CENTER_Y: cen_y = data;
      cor_pkg::REG_RADIUS:   rad = data[cor_pkg::RAD_W-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited_pts.size();
  endfunction

  // coordinate below the centre, truncated toward zero from c - sqrt(d)
  function int below(int c, int s, bit exact);
    if (exact || c <= s) return c - s;
    return c - s - 1;
  endfunction

  function void add_pt(int k, int x_val, int y_val, bit fin);
    point_t p;
    p.px = x_val[cor_pkg::OUT_W-1:0];
    p.py = y_val[cor_pkg::OUT_W-1:0];
    p.last_pt = (k == 7);
    p.done_pt = fin;
    awaited_pts.push_back(p);
  endfunction

  function void note_step(logic restart);
    int unsigned rr, xx, d, s, t;
    int k, a, b, x, na, nb;
    bit exact, fin;
    steps_seen++;
    if (restart) begin
      column = '0;
      finished = 1'b0;
    end
    if (finished) return;
    rr = 32'(rad) * 32'(rad);
    xx = 32'(column) * 32'(column);
    d = (rr > xx) ? rr - xx : 0;
    s = 0;
    for (k = 11; k >= 0; k--) begin
      t = s | (1 << k);
      if (t * t <= d) s = t;
    end
    exact = (s * s == d);
    a = int'(cen_x);
    b = int'(cen_y);
    x = int'(column);
    nb = below(b, s, exact);
    na = below(a, s, exact);
    fin = (x + 1 > int'(s));
    add_pt(0, a + x, b + s, fin);
    add_pt(1, a - x, b + s, fin);
    add_pt(2, a + x, nb, fin);
    add_pt(3, a - x, nb, fin);
    add_pt(4, a + s, b + x, fin);
    add_pt(5, na, b + x, fin);
    add_pt(6, a + s, b - x, fin);
    add_pt(7, na, b - x, fin);
    steps_drawn++;
    if (fin) begin
      finished = 1'b1;
      circles++;
    end else begin
      column = column + cor_pkg::COORD_BITS'(1);
    end
  endfunction

  function void check_point(point_t got);
    point_t want;
    bit bad;
    if (awaited_pts.size() == 0) begin
      errors++;
      $display("%0t: point (%0d,%0d) arrived with nothing awaited", $time,
               $signed(got.px), $signed(got.py));
      return;
    end
    want = awaited_pts.pop_front();
    bad = 1'b0;
    if (got.px !== want.px) begin
      bad = 1'b1;
      $display("%0t: point_x expected %0d actual %0d", $time, $signed(want.px),
               $signed(got.px));
    end
    if (got.py !== want.py) begin
      bad = 1'b1;
      $display("%0t: point_y expected %0d actual %0d", $time, $signed(want.py),
               $signed(got.py));
    end
    if (got.last_pt !== want.last_pt) begin
      bad = 1'b1;
      $display("%0t: last_of_step expected %0b actual %0b", $time, want.last_pt,
               got.last_pt);
    end
    if (got.done_pt !== want.done_pt) begin
      bad = 1'b1;
      $display("%0t: circle_done expected %0b actual %0b", $time, want.done_pt,
               got.done_pt);
    end
    if (bad) errors++;
    else points_ok++;
  endfunction
endclass

module circle_octant_rasterizer_top_tb;

  localparam logic [cor_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 30;

  logic clk_i;
  logic rst_ni;
  bit   no_gaps;
  int unsigned quiet_from;

  circle_scoreboard sb;

  cor_step_if  step_ch();
  cor_point_if pt_ch();
  cor_cfg_if   cfg_ch();

  circle_octant_rasterizer_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step_ch),
    .point_o (pt_ch),
    .cfg_i   (cfg_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver side: random back-pressure outside the quiet stretch
  initial begin
    pt_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      pt_ch.ready <= no_gaps || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pt_ch.valid && pt_ch.ready) begin
      sb.check_point('{pt_ch.point_x, pt_ch.point_y, pt_ch.last_of_step,
                       pt_ch.circle_done});
    end
  end

  initial begin
    #(4 * 400000);
    $display("circle_octant_rasterizer_top: mismatch");
    $finish;
  end

  // leaves valid high so that a following item goes out without a gap
  task automatic send_step(input logic restart);
    no_gaps = (sb.steps_drawn >= quiet_from) && (sb.steps_drawn < quiet_from + 50);
    while (!no_gaps && $urandom_range(99) < 19) begin
      step_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    step_ch.valid <= 1'b1;
    step_ch.restart <= restart;
    do @(posedge clk_i); while (!step_ch.ready);
    sb.note_step(restart);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [cor_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cor_pkg::COORD_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_circle(input logic [cor_pkg::COORD_BITS-1:0] cx,
                            input logic [cor_pkg::COORD_BITS-1:0] cy,
                            input logic [cor_pkg::COORD_BITS-1:0] r);
    write_reg(cor_pkg::REG_CENTER_X, cx);
    write_reg(cor_pkg::REG_CENTER_Y, cy);
    write_reg(cor_pkg::REG_RADIUS, r);
  endtask

  // stop stepping, let every point drain and the block go idle
  task automatic settle();
    step_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    int unsigned base, cap, n, roll;
    logic [cor_pkg::COORD_BITS-1:0] cx, cy, r;
    sb = new();
    no_gaps = 1'b0;
    quiet_from = 32'hFFFF_FFFF;
    rst_ni = 1'b0;
    step_ch.valid = 1'b0;
    step_ch.restart = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = cor_pkg::REG_CENTER_X;
    cfg_ch.data = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // nothing to draw straight after reset
    send_step(1'b0);
    settle();
    // zero radius: a single step of eight points on the centre
    set_circle(12'd0, 12'd0, 12'd0);
    send_step(1'b1);
    send_step(1'b0);
    settle();
    // largest circle at the top corner, bit above the radius field set
    set_circle(12'd4095, 12'd4095, 12'hFFF);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    settle();
    // largest circle at the origin: offsets below zero
    set_circle(12'd0, 12'd0, 12'd2047);
    send_step(1'b1);
    send_step(1'b0);
    settle();
    // radius shrunk under the column mid-run: radicand clamps to zero
    set_circle(12'd100, 12'd100, 12'd5);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    settle();
    write_reg(cor_pkg::REG_RADIUS, 12'd1);
    send_step(1'b0);
    settle();
    // write to the unused index changes nothing
    set_circle(12'd10, 12'd20, 12'd3);
    write_reg(REG_SPARE, 12'hFFF);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b0);
    settle();
    set_circle(12'd2, 12'd4093, 12'd1);
    send_step(1'b1);
    send_step(1'b0);
    settle();
    // restart in the middle of a circle
    set_circle(12'd1000, 12'd3000, 12'd10);
    send_step(1'b1);
    send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    settle();

    base = sb.steps_drawn;
    quiet_from = base + 80;
    while (sb.steps_drawn - base < 180) begin
      roll = $urandom_range(99);
      cx = ($urandom_range(9) == 0) ? 12'(($urandom_range(1)) * 4095) : 12'($urandom);
      cy = ($urandom_range(9) == 0) ? 12'(($urandom_range(1)) * 4095) : 12'($urandom);
      if (roll < 6) begin
        r = 12'($urandom_range(1024, 2047));
        cap = $urandom_range(2, 6);
      end else begin
        r = 12'($urandom_range(0, 30));
        cap = ($urandom_range(99) < 15) ? $urandom_range(1, 8) : 60;
      end
      r[11] = $urandom_range(1);
      set_circle(cx, cy, r);
      if ($urandom_range(99) < 10) send_step(1'b0);
      send_step(1'b1);
      n = 1;
      while (!sb.finished && n < cap) begin
        send_step($urandom_range(99) < 5);
        n++;
      end
      if (!sb.finished && $urandom_range(1) == 1) begin
        settle();
        write_reg(cor_pkg::REG_RADIUS, 12'($urandom_range(0, sb.column + 2)));
        n = 0;
        while (!sb.finished && n < 40) begin
          send_step(1'b0);
          n++;
        end
      end
      if ($urandom_range(99) < 30) repeat ($urandom_range(1, 2)) send_step(1'b0);
      settle();
    end

    repeat (40) @(negedge clk_i);
    $display("steps sent %0d, of which %0d drew points; %0d circles closed",
             sb.steps_seen, sb.steps_drawn, sb.circles);
    $display("points checked good %0d, failures %0d", sb.points_ok, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("circle_octant_rasterizer_top: match");
    end else begin
      $display("circle_octant_rasterizer_top: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/cor_pkg.sv
rtl/cor_if.sv
rtl/cor_ctrl.sv
rtl/cor_datapath.sv
rtl/circle_octant_rasterizer_top.sv
rtl/cor_checker.sv
tb/sv/circle_octant_rasterizer_top_tb.sv
